FILE: src/lrfcs_pkg.sv
// Shared types, constants and functions for the four-cell life rule strip.
`default_nettype none
package lrfcs_pkg;

	localparam int WindowW = 18;
	localparam int RowLen  = 6;
	localparam int NumLanes = 4;
	localparam int RuleW   = 9;
	localparam int CountW  = 4;
	localparam int IndexW  = 2;

	// Register indexes on the write port
	localparam logic [IndexW-1:0] REG_BIRTH   = 2'd0;
	localparam logic [IndexW-1:0] REG_SURVIVE = 2'd1;

	// Birth and survival masks as one group
	typedef struct packed {
		logic [RuleW-1:0] birth;
		logic [RuleW-1:0] survive;
	} rule_t;

	// 3x3 neighborhood: row2 in [8:6], row1 in [5:3], row0 in [2:0]; center at bit 4
	typedef logic [8:0] nbhd_t;

	// Count of live neighbors: all bits but the center
	function automatic logic [CountW-1:0] live_count(input nbhd_t nb);
		logic [CountW-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				cnt = cnt + CountW'(nb[i]);
			end
		end
		return cnt;
	endfunction

endpackage
`default_nettype wire

FILE: src/life_rule_four_cell_strip_core.sv
// Top level: window register, four cell lanes, merged output register, rule registers.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------
//  in      | in        | in_valid / in_stall | window[17:0]
//  out     | out       | out_valid/out_stall | next_cells[3:0]
//  config  | in        | wr_en               | wr_index[1:0], wr_data[8:0]
//
// One window per cycle while in_stall is low; the window register and the output register lie between input and output.
// Four lanes evaluate the four center cells in parallel, combinationally.
// Reset clears both pipeline valids and loads birth 8, survive 12.
// An out_stall holds the output word; the window stage keeps filling until
// both stages are full, then in_stall rises.
`default_nettype none
module life_rule_four_cell_strip_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lrfcs_pkg::WindowW-1:0]    window,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lrfcs_pkg::NumLanes-1:0]   next_cells,
	input  logic                             wr_en,
	input  logic [lrfcs_pkg::IndexW-1:0]     wr_index,
	input  logic [lrfcs_pkg::RuleW-1:0]      wr_data
);
	import lrfcs_pkg::*;

	rule_t               rule_q;
	logic                valid_s1;
	logic [WindowW-1:0]  window_s1;
	logic [NumLanes-1:0] lane_bits;
	logic                adv2;
	logic                adv1;

	// Rule registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q.birth   <= RuleW'(8);
			rule_q.survive <= RuleW'(12);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BIRTH:   rule_q.birth   <= wr_data;
				REG_SURVIVE: rule_q.survive <= wr_data;
				default: ;
			endcase
		end
	end

	// Window stage moves when empty or when the merge stage takes its word
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			window_s1 <= window;
		end
	end

	// One lane per center cell, column j+1 of row 1
	for (genvar j = 0; j < NumLanes; j++) begin : g_lane
		localparam int Col = j + 1;
		nbhd_t nb;
		assign nb = {window_s1[2*RowLen + Col - 1 +: 3],
		             window_s1[RowLen + Col - 1 +: 3],
		             window_s1[Col - 1 +: 3]};
		lrfcs_lane u_lane (
			.nbhd      (nb),
			.rule      (rule_q),
			.next_cell (lane_bits[j])
		);
	end

	lrfcs_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (valid_s1),
		.lane_bits  (lane_bits),
		.advance    (adv2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.next_cells (next_cells)
	);

endmodule
`default_nettype wire

FILE: src/lrfcs_lane.sv
// One lane: next state of one center-row cell from its 3x3 neighborhood.
`default_nettype none
module lrfcs_lane (
	input  var lrfcs_pkg::nbhd_t nbhd,
	input  var lrfcs_pkg::rule_t rule,
	output logic                 next_cell
);
	import lrfcs_pkg::*;

	logic [CountW-1:0] cnt;
	logic              self_alive;

	// Neighbor count picks one mask bit; cell state picks the mask
	assign cnt        = live_count(nbhd);
	assign self_alive = nbhd[4];

	always_comb begin
		if (self_alive) begin
			next_cell = rule.survive[cnt];
		end else begin
			next_cell = rule.birth[cnt];
		end
	end

endmodule
`default_nettype wire

FILE: src/lrfcs_merge.sv
// Merge stage: gathers the lane results into the registered output word.
`default_nettype none
module lrfcs_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            lane_valid,
	input  logic [lrfcs_pkg::NumLanes-1:0]  lane_bits,
	output logic                            advance,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lrfcs_pkg::NumLanes-1:0]  next_cells
);
	import lrfcs_pkg::*;

	logic                valid_s2;
	logic [NumLanes-1:0] cells_s2;

	// Output register takes a new word when empty or when its word transfers
	assign advance = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= lane_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (advance && lane_valid) begin
			cells_s2 <= lane_bits;
		end
	end

	assign out_valid  = valid_s2;
	assign next_cells = cells_s2;

endmodule
`default_nettype wire
